@@ design/sorted_ring_priority_queue_top_assert.svh @@
// Assertion macros for the sorted ring priority queue.
// Used by sorted_ring_priority_queue_top; needs clk and rst_n in scope at the point of use.
`ifndef SORTED_RING_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_RING_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTH
// The condition holds at every clock edge out of reset.
`define SRPQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("srpq assertion failed");
// The consequence holds in the same cycle as the antecedent.
`define SRPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srpq assertion failed");
// The consequence holds in the cycle after the antecedent.
`define SRPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srpq assertion failed");
`else
`define SRPQ_ASSERT_ALWAYS(label, cond)
`define SRPQ_ASSERT_NOW(label, ante, cons)
`define SRPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/srpq_pkg.sv @@
// Package of the sorted ring priority queue: sizes, command codes, request and result types.
// Depends on nothing; used by sorted_ring_priority_queue_top.
`default_nettype none

package srpq_pkg;

    localparam int SLOTS    = 64;
    localparam int PTR_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS);
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [HANDLE_W-1:0] handle_t;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef struct packed {
        logic    command;
        key_t    entry_key;
        handle_t entry_handle;
    } req_t;

    typedef struct packed {
        logic    accepted;
        logic    out_valid;
        key_t    out_key;
        handle_t out_handle;
        logic    now_empty;
        logic    now_full;
    } rsp_t;

    typedef struct packed {
        key_t    key;
        handle_t handle;
    } entry_t;

    function automatic ptr_t ring_next(input ptr_t p);
        return (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic ptr_t ring_prev(input ptr_t p);
        return (p == '0) ? PTR_W'(SLOTS - 1) : p - PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ design/sorted_ring_priority_queue_top.sv @@
// Throughput: one request at a time; a refused enqueue or an empty dequeue goes from IDLE to
// DONE, a dequeue through DEQ to DONE and an enqueue through WALK to DONE, where WALK moves up
// the k (up to SLOTS - 2) stored keys not below the new key, one slot read, compared and
// moved per cycle. Results: each waits in DONE until the output register is free, and
// a result still waiting on a stall holds the next one in the sequencer.
// Reset: asynchronous, active low; clears the pointers, count and control, not the entry memory.
`default_nettype none

`include "sorted_ring_priority_queue_top_assert.svh"

module sorted_ring_priority_queue_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire srpq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output srpq_pkg::rsp_t     rsp
);

    // The sequencer. IDLE takes a request and already reads the slot that the request needs
    // first: the head for a dequeue, the slot just below the tail for an enqueue.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DEQ  = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    srpq_pkg::ptr_t head_reg, head_next;
    srpq_pkg::ptr_t tail_reg, tail_next;
    srpq_pkg::cnt_t count_reg, count_next;

    // Walk position: the free slot that the next moved entry or the new entry lands in,
    // and the number of stored entries below it that have not yet been compared.
    srpq_pkg::ptr_t j_reg, j_next;
    srpq_pkg::cnt_t rem_reg, rem_next;

    srpq_pkg::entry_t new_reg, new_next;
    srpq_pkg::rsp_t   res_reg, res_next;

    logic           rsp_valid_reg, rsp_valid_next;
    srpq_pkg::rsp_t rsp_reg;

    // Entry memory: one write port and one registered read port.
    srpq_pkg::entry_t mem [srpq_pkg::SLOTS];
    srpq_pkg::entry_t rdata_reg;
    srpq_pkg::ptr_t   rd_addr;
    srpq_pkg::ptr_t   wr_addr;
    srpq_pkg::entry_t wr_data;
    logic             wr_en;

    logic is_empty;
    logic is_full;
    logic push;
    logic shift_up;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == srpq_pkg::CNT_W'(srpq_pkg::SLOTS - 1));

    // The result leaves the sequencer once the output register is free or being emptied.
    assign push = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    // During the walk the registered read data is the entry just below the free slot. It moves
    // up while its key is not below the new key, which puts the new entry ahead of equal keys.
    assign shift_up = (rem_reg != '0) && (rdata_reg.key >= new_reg.key);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        rem_next       = rem_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = j_reg;
        wr_data        = new_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (req.command == srpq_pkg::CMD_DEQUEUE) ? head_reg
                                                                 : srpq_pkg::ring_prev(tail_reg);
                if (req_valid)
                begin
                    res_next           = '0;
                    res_next.now_empty = is_empty;
                    res_next.now_full  = is_full;
                    if (req.command == srpq_pkg::CMD_ENQUEUE)
                    begin
                        if (is_full)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            new_next.key    = req.entry_key;
                            new_next.handle = req.entry_handle;
                            j_next          = tail_reg;
                            rem_next        = count_reg;
                            state_next      = ST_WALK;
                        end
                    end
                    else
                    begin
                        state_next = is_empty ? ST_DONE : ST_DEQ;
                    end
                end
            end

            ST_DEQ:
            begin
                res_next.out_valid  = 1'b1;
                res_next.out_key    = rdata_reg.key;
                res_next.out_handle = rdata_reg.handle;
                res_next.now_empty  = (count_reg == srpq_pkg::CNT_W'(1));
                res_next.now_full   = 1'b0;
                head_next           = srpq_pkg::ring_next(head_reg);
                count_next          = count_reg - srpq_pkg::CNT_W'(1);
                state_next          = ST_DONE;
            end

            ST_WALK:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if (shift_up)
                begin
                    wr_data  = rdata_reg;
                    j_next   = srpq_pkg::ring_prev(j_reg);
                    rem_next = rem_reg - srpq_pkg::CNT_W'(1);
                    rd_addr  = srpq_pkg::ring_prev(srpq_pkg::ring_prev(j_reg));
                end
                else
                begin
                    wr_data            = new_reg;
                    tail_next          = srpq_pkg::ring_next(tail_reg);
                    count_next         = count_reg + srpq_pkg::CNT_W'(1);
                    res_next.accepted  = 1'b1;
                    res_next.now_empty = 1'b0;
                    res_next.now_full  =
                        (count_reg == srpq_pkg::CNT_W'(srpq_pkg::SLOTS - 2));
                    state_next         = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (push)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            j_reg         <= '0;
            rem_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            j_reg         <= j_next;
            rem_reg       <= rem_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        res_reg <= res_next;
        if (push)
        begin
            rsp_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // The count and the two pointers describe the same ring.
    `SRPQ_ASSERT_ALWAYS(a_ring_consistent,
        (int'(head_reg) + int'(count_reg) == int'(tail_reg)) ||
        (int'(head_reg) + int'(count_reg) == int'(tail_reg) + srpq_pkg::SLOTS))
    // The walk never has more entries left to compare than the queue holds.
    `SRPQ_ASSERT_NOW(a_walk_bounded, state_reg == ST_WALK, rem_reg <= count_reg)
    // A result is either a stored enqueue or a returned entry, never both.
    `SRPQ_ASSERT_NOW(a_rsp_one_kind, rsp_valid_reg, !(rsp_reg.accepted && rsp_reg.out_valid))
    // A result never reports an empty and a full queue at once.
    `SRPQ_ASSERT_NOW(a_rsp_status, rsp_valid_reg, !(rsp_reg.now_empty && rsp_reg.now_full))
    // Once an enqueue finishes its walk the tail has advanced by one slot.
    `SRPQ_ASSERT_NEXT(a_tail_advance, state_reg == ST_WALK && !shift_up,
        tail_reg == srpq_pkg::ring_next($past(tail_reg)))

endmodule

`default_nettype wire
